[rtl/ir_range_table_calibrate_lookup_defines.svh]
// Assertion helpers shared by the calibrated range lookup RTL.
// Both macros sample on the rising edge of clk_i and are disabled in reset.
`ifndef IR_RANGE_TABLE_CALIBRATE_LOOKUP_DEFINES_SVH
`define IR_RANGE_TABLE_CALIBRATE_LOOKUP_DEFINES_SVH

// Same-cycle implication
`define IRTCL_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define IRTCL_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/irtcl_pkg.sv]
package irtcl_pkg;

  // Default geometry
  localparam int unsigned DEF_TABLE_DEPTH   = 130;
  localparam int unsigned DEF_POINT_SPACING = 10;
  localparam int unsigned DEF_CAL_POINTS    = 13;
  localparam int unsigned DEF_SAMPLE_BITS   = 12;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DIST_W   = 9;
  localparam int unsigned POINT_W  = 4;
  localparam int unsigned OFFSET_W = 8;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd20;

  // Input transaction
  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } irtcl_in_t;

  // Output transaction
  typedef struct packed {
    logic [DIST_W-1:0]  distance_a;
    logic [DIST_W-1:0]  distance_b;
    logic [POINT_W-1:0] point_written;
    logic               run_done;
  } irtcl_out_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAL_WRITE,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_FILL,
    OP_COARSE,
    OP_FINE,
    OP_OUT
  } irtcl_op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_MEASURE,
    C_NO_FILL,
    C_FILL_BUSY,
    C_COARSE_BUSY,
    C_FINE_BUSY,
    C_OUT_FREE
  } irtcl_cond_e;

  // Program steps
  typedef enum logic [3:0] {
    S_WAIT,
    S_DISP,
    S_CALST,
    S_CALLD,
    S_DIV,
    S_FILL,
    S_COARSE,
    S_FINE,
    S_OUT
  } irtcl_step_e;

  // One control word: operation, condition and both successors
  typedef struct packed {
    irtcl_op_e   op;
    irtcl_cond_e cond;
    irtcl_step_e nxt_t;
    irtcl_step_e nxt_f;
    logic        take;
  } irtcl_uword_t;

  // Status flags seen by the sequencer
  typedef struct packed {
    logic accept;
    logic measure;
    logic no_fill;
    logic fill_busy;
    logic coarse_busy;
    logic fine_busy;
    logic out_free;
  } irtcl_flags_t;

  // Control into one sensor lane
  typedef struct packed {
    irtcl_op_e op;
    logic      load;
    logic      wr_en;
  } irtcl_lane_ctrl_t;

  // Search status out of one sensor lane
  typedef struct packed {
    logic coarse_end;
    logic fine_end;
  } irtcl_lane_stat_t;

  // Control store
  function automatic irtcl_uword_t irtcl_ucode(input irtcl_step_e step);
    irtcl_uword_t w;
    case (step)
      S_WAIT:   w = '{op: OP_LOAD, cond: C_ACCEPT, nxt_t: S_DISP, nxt_f: S_WAIT,
                      take: 1'b1};
      S_DISP:   w = '{op: OP_NONE, cond: C_MEASURE, nxt_t: S_COARSE, nxt_f: S_CALST,
                      take: 1'b0};
      S_CALST:  w = '{op: OP_CAL_WRITE, cond: C_NO_FILL, nxt_t: S_OUT, nxt_f: S_CALLD,
                      take: 1'b0};
      S_CALLD:  w = '{op: OP_DIV_LOAD, cond: C_ALWAYS, nxt_t: S_DIV, nxt_f: S_DIV,
                      take: 1'b0};
      S_DIV:    w = '{op: OP_DIV_STEP, cond: C_ALWAYS, nxt_t: S_FILL, nxt_f: S_FILL,
                      take: 1'b0};
      S_FILL:   w = '{op: OP_FILL, cond: C_FILL_BUSY, nxt_t: S_FILL, nxt_f: S_OUT,
                      take: 1'b0};
      S_COARSE: w = '{op: OP_COARSE, cond: C_COARSE_BUSY, nxt_t: S_COARSE, nxt_f: S_FINE,
                      take: 1'b0};
      S_FINE:   w = '{op: OP_FINE, cond: C_FINE_BUSY, nxt_t: S_FINE, nxt_f: S_OUT,
                      take: 1'b0};
      S_OUT:    w = '{op: OP_OUT, cond: C_OUT_FREE, nxt_t: S_WAIT, nxt_f: S_OUT,
                      take: 1'b0};
      default:  w = '{op: OP_NONE, cond: C_ALWAYS, nxt_t: S_WAIT, nxt_f: S_WAIT,
                      take: 1'b0};
    endcase
    return w;
  endfunction

endpackage

[rtl/irtcl_ram.sv]
module irtcl_ram #(
  parameter int unsigned WIDTH = irtcl_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned DEPTH = irtcl_pkg::DEF_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/irtcl_seq.sv]
module irtcl_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  irtcl_pkg::irtcl_flags_t flags_i,
  output irtcl_pkg::irtcl_uword_t uword_o
);

  irtcl_pkg::irtcl_step_e  pc_q, pc_d;
  irtcl_pkg::irtcl_uword_t uw;
  logic                    hit;

  // Fetch the control word and resolve the jump
  always_comb begin
    uw = irtcl_pkg::irtcl_ucode(pc_q);
    case (uw.cond)
      irtcl_pkg::C_ALWAYS:      hit = 1'b1;
      irtcl_pkg::C_ACCEPT:      hit = flags_i.accept;
      irtcl_pkg::C_MEASURE:     hit = flags_i.measure;
      irtcl_pkg::C_NO_FILL:     hit = flags_i.no_fill;
      irtcl_pkg::C_FILL_BUSY:   hit = flags_i.fill_busy;
      irtcl_pkg::C_COARSE_BUSY: hit = flags_i.coarse_busy;
      irtcl_pkg::C_FINE_BUSY:   hit = flags_i.fine_busy;
      irtcl_pkg::C_OUT_FREE:    hit = flags_i.out_free;
      default:                  hit = 1'b0;
    endcase
    pc_d = hit ? uw.nxt_t : uw.nxt_f;
  end

  // Advance the step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= irtcl_pkg::S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uword_o = uw;

endmodule

[rtl/irtcl_lane.sv]
module irtcl_lane #(
  parameter int unsigned TABLE_DEPTH   = irtcl_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned POINT_SPACING = irtcl_pkg::DEF_POINT_SPACING,
  parameter int unsigned CAL_POINTS    = irtcl_pkg::DEF_CAL_POINTS,
  parameter int unsigned SAMPLE_BITS   = irtcl_pkg::DEF_SAMPLE_BITS,
  localparam int unsigned PROBE_MAX    = (TABLE_DEPTH > CAL_POINTS * POINT_SPACING) ?
                                         TABLE_DEPTH : CAL_POINTS * POINT_SPACING,
  localparam int unsigned IDX_W        = $clog2(PROBE_MAX + POINT_SPACING),
  localparam int unsigned K_W          = $clog2(POINT_SPACING),
  localparam int unsigned HWM_W        = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  irtcl_pkg::irtcl_lane_ctrl_t       ctrl_i,
  input  logic [irtcl_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [IDX_W-1:0]                  base_i,
  input  logic [K_W-1:0]                    k_i,
  input  logic [HWM_W-1:0]                  hwm_i,
  output irtcl_pkg::irtcl_lane_stat_t       stat_o,
  output logic [IDX_W-1:0]                  idx_o
);

  localparam int unsigned ADDR_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned COARSE_LIM = (CAL_POINTS * POINT_SPACING < TABLE_DEPTH) ?
                                       CAL_POINTS * POINT_SPACING : TABLE_DEPTH;
  localparam int unsigned DIV_SH     = SAMPLE_BITS + $clog2(POINT_SPACING);
  localparam int unsigned RECIP      = ((1 << DIV_SH) + POINT_SPACING - 1) / POINT_SPACING;

  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   cdone_q, cdone_d;
  logic                   fdone_q, fdone_d;
  logic [SAMPLE_BITS-1:0] dq_q, dq_d;
  logic                   neg_q, neg_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;

  logic                   we;
  logic [IDX_W-1:0]       waddr_w;
  logic [SAMPLE_BITS-1:0] wdata;
  logic [IDX_W-1:0]       raddr_w;
  logic [ADDR_W-1:0]      raddr;
  logic [SAMPLE_BITS-1:0] rdata;

  logic [SAMPLE_BITS-1:0]        entry;
  logic                          hit_c;
  logic                          hit_f;
  logic [2*SAMPLE_BITS:0]        quot_p;
  logic signed [SAMPLE_BITS:0]   diff_s;
  logic [SAMPLE_BITS:0]          mag_w;
  logic signed [SAMPLE_BITS:0]   step_s;
  logic signed [SAMPLE_BITS+1:0] fill_v;
  logic [SAMPLE_BITS-1:0]        fill_c;

  // Table entry at idx_q; entries at or above the fill mark read as zero
  assign entry = (IDX_W'(hwm_i) > idx_q) ? rdata : '0;
  assign hit_c = (idx_q < IDX_W'(COARSE_LIM)) && (entry > sample_q);
  assign hit_f = (idx_q != '0) && (entry < sample_q);

  assign stat_o.coarse_end = cdone_q || !hit_c;
  assign stat_o.fine_end   = fdone_q || !hit_f;
  assign idx_o             = idx_q;

  // Divide the magnitude by the point spacing with a reciprocal multiply,
  // exact over the whole sample range
  assign quot_p = {{(SAMPLE_BITS + 1){1'b0}}, dq_q} * (2 * SAMPLE_BITS + 1)'(RECIP);

  // Signed difference to the previous calibration point
  assign diff_s = $signed({1'b0, sample_q}) - $signed({1'b0, rdata});
  assign mag_w  = diff_s[SAMPLE_BITS] ? -diff_s : diff_s;

  // Interpolation step and clamped next entry
  assign step_s = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
  assign fill_v = $signed({2'b00, prev_q}) - $signed({step_s[SAMPLE_BITS], step_s});

  always_comb begin
    if (fill_v[SAMPLE_BITS+1]) begin
      fill_c = '0;
    end else if (fill_v[SAMPLE_BITS]) begin
      fill_c = '1;
    end else begin
      fill_c = fill_v[SAMPLE_BITS-1:0];
    end
  end

  // Datapath operation selected by the control word
  always_comb begin
    sample_d = sample_q;
    idx_d    = idx_q;
    cdone_d  = cdone_q;
    fdone_d  = fdone_q;
    dq_d     = dq_q;
    neg_d    = neg_q;
    prev_d   = prev_q;
    we       = 1'b0;
    waddr_w  = base_i;
    wdata    = sample_q;
    case (ctrl_i.op)
      irtcl_pkg::OP_LOAD: begin
        if (ctrl_i.load) begin
          sample_d = SAMPLE_BITS'(sample_i);
          idx_d    = '0;
          cdone_d  = 1'b0;
          fdone_d  = 1'b0;
        end
      end
      irtcl_pkg::OP_CAL_WRITE: begin
        we = ctrl_i.wr_en;
      end
      irtcl_pkg::OP_DIV_LOAD: begin
        neg_d  = diff_s[SAMPLE_BITS];
        dq_d   = mag_w[SAMPLE_BITS-1:0];
        prev_d = sample_q;
      end
      irtcl_pkg::OP_DIV_STEP: begin
        dq_d = SAMPLE_BITS'(quot_p >> DIV_SH);
      end
      irtcl_pkg::OP_FILL: begin
        we      = 1'b1;
        waddr_w = base_i - IDX_W'(k_i);
        wdata   = fill_c;
        prev_d  = fill_c;
      end
      irtcl_pkg::OP_COARSE: begin
        if (!cdone_q) begin
          if (hit_c) begin
            idx_d = idx_q + IDX_W'(POINT_SPACING);
          end else begin
            cdone_d = 1'b1;
            idx_d   = (idx_q >= IDX_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : idx_q;
          end
        end
      end
      irtcl_pkg::OP_FINE: begin
        if (!fdone_q) begin
          if (hit_f) begin
            idx_d = idx_q - 1'b1;
          end else begin
            fdone_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    // Read the previous point during the write, else follow the search index
    raddr_w = (ctrl_i.op == irtcl_pkg::OP_CAL_WRITE) ?
              base_i - IDX_W'(POINT_SPACING) : idx_d;
    raddr   = (raddr_w < IDX_W'(TABLE_DEPTH)) ? raddr_w[ADDR_W-1:0] : '0;
  end

  // Hold search flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cdone_q <= 1'b1;
      fdone_q <= 1'b1;
    end else begin
      cdone_q <= cdone_d;
      fdone_q <= fdone_d;
    end
  end

  // Hold datapath values
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    idx_q    <= idx_d;
    dq_q     <= dq_d;
    neg_q    <= neg_d;
    prev_q   <= prev_d;
  end

  irtcl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_w[ADDR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

[rtl/ir_range_table_calibrate_lookup.sv]
// Measure: after input accept, a coarse search probes the table every POINT_SPACING entries,
// then a fine search steps back one entry at a time, and the result enters the out reg.
// Calibrate: a point after point 0 that is in the table and does not end the run is filled back
// to the previous point with one reciprocal divide step and one table write per fill entry.
// One transaction at a time; the next is taken only once the result has entered the out reg.
// Async active-low reset clears the point counter, fill mark, offset (to 20) and out valid.
`include "ir_range_table_calibrate_lookup_defines.svh"

module ir_range_table_calibrate_lookup #(
  parameter int unsigned TABLE_DEPTH   = irtcl_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned POINT_SPACING = irtcl_pkg::DEF_POINT_SPACING,
  parameter int unsigned CAL_POINTS    = irtcl_pkg::DEF_CAL_POINTS,
  parameter int unsigned SAMPLE_BITS   = irtcl_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  irtcl_pkg::irtcl_in_t              in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output irtcl_pkg::irtcl_out_t             out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [irtcl_pkg::OFFSET_W-1:0]    cfg_data_i
);

  localparam int unsigned PROBE_MAX = (TABLE_DEPTH > CAL_POINTS * POINT_SPACING) ?
                                      TABLE_DEPTH : CAL_POINTS * POINT_SPACING;
  localparam int unsigned IDX_W     = $clog2(PROBE_MAX + POINT_SPACING);
  localparam int unsigned K_W       = $clog2(POINT_SPACING);
  localparam int unsigned HWM_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CNT_W     = $clog2(CAL_POINTS + 1);
  localparam int unsigned DIST_W    = irtcl_pkg::DIST_W;
  localparam int unsigned POINT_W   = irtcl_pkg::POINT_W;

  irtcl_pkg::irtcl_uword_t     uw;
  irtcl_pkg::irtcl_flags_t     flags;
  irtcl_pkg::irtcl_lane_ctrl_t lane_ctrl;
  irtcl_pkg::irtcl_lane_stat_t stat_a, stat_b;
  logic [IDX_W-1:0]            idx_a, idx_b;

  logic                          accept;
  logic                          run_end;
  logic                          in_range;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [HWM_W-1:0]              hwm_q, hwm_d;
  logic [irtcl_pkg::OFFSET_W-1:0] offset_q;
  logic                          out_valid_q, out_valid_d;
  irtcl_pkg::irtcl_out_t         out_q, out_d;
  logic                          act_q, act_d;
  logic [IDX_W-1:0]              base_q, base_d;
  logic [K_W-1:0]                k_q, k_d;
  logic [CNT_W-1:0]              point_q, point_d;
  logic                          done_q, done_d;

  // Handshake and status
  assign accept      = in_valid_i && uw.take;
  assign in_stall_o  = !uw.take;
  assign cfg_ready_o = 1'b1;
  assign run_end     = (cnt_q == CNT_W'(CAL_POINTS));
  assign in_range    = (base_q < IDX_W'(TABLE_DEPTH));

  assign flags.accept      = accept;
  assign flags.measure     = !act_q;
  assign flags.no_fill     = run_end || !in_range || (cnt_q == '0);
  assign flags.fill_busy   = (k_q != K_W'(POINT_SPACING - 1));
  assign flags.coarse_busy = !(stat_a.coarse_end && stat_b.coarse_end);
  assign flags.fine_busy   = !(stat_a.fine_end && stat_b.fine_end);
  assign flags.out_free    = !out_valid_q || !out_stall_i;

  assign lane_ctrl.op    = uw.op;
  assign lane_ctrl.load  = accept;
  assign lane_ctrl.wr_en = !run_end && in_range;

  // Shared control and result registers
  always_comb begin
    cnt_d       = cnt_q;
    hwm_d       = hwm_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    act_d       = act_q;
    base_d      = base_q;
    k_d         = k_q;
    point_d     = point_q;
    done_d      = done_q;
    case (uw.op)
      irtcl_pkg::OP_LOAD: begin
        if (accept) begin
          act_d  = in_item_i.action;
          base_d = IDX_W'(cnt_q * POINT_SPACING);
        end
      end
      irtcl_pkg::OP_CAL_WRITE: begin
        point_d = run_end ? CNT_W'(CAL_POINTS) : cnt_q;
        done_d  = run_end;
        cnt_d   = run_end ? '0 : cnt_q + 1'b1;
        if (lane_ctrl.wr_en && (IDX_W'(hwm_q) <= base_q)) begin
          hwm_d = HWM_W'(base_q + 1'b1);
        end
      end
      irtcl_pkg::OP_DIV_LOAD: begin
        k_d = K_W'(1);
      end
      irtcl_pkg::OP_FILL: begin
        k_d = k_q + 1'b1;
      end
      irtcl_pkg::OP_OUT: begin
        if (flags.out_free) begin
          out_valid_d = 1'b1;
          if (act_q) begin
            out_d.distance_a    = '0;
            out_d.distance_b    = '0;
            out_d.point_written = POINT_W'(point_q);
            out_d.run_done      = done_q;
          end else begin
            out_d.distance_a    = DIST_W'(32'(idx_a) + 32'(offset_q));
            out_d.distance_b    = DIST_W'(32'(idx_b) + 32'(offset_q));
            out_d.point_written = '0;
            out_d.run_done      = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Hold control state and the offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hwm_q       <= '0;
      offset_q    <= irtcl_pkg::OFFSET_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        offset_q <= cfg_data_i;
      end
    end
  end

  // Hold transaction payload
  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    act_q   <= act_d;
    base_q  <= base_d;
    k_q     <= k_d;
    point_q <= point_d;
    done_q  <= done_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  irtcl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  irtcl_lane #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .POINT_SPACING (POINT_SPACING),
    .CAL_POINTS    (CAL_POINTS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .sample_i (in_item_i.sample_a),
    .base_i   (base_q),
    .k_i      (k_q),
    .hwm_i    (hwm_q),
    .stat_o   (stat_a),
    .idx_o    (idx_a)
  );

  irtcl_lane #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .POINT_SPACING (POINT_SPACING),
    .CAL_POINTS    (CAL_POINTS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .sample_i (in_item_i.sample_b),
    .base_i   (base_q),
    .k_i      (k_q),
    .hwm_i    (hwm_q),
    .stat_o   (stat_b),
    .idx_o    (idx_b)
  );

  // Checks on sequencing and calibration state
  `IRTCL_ASSERT_NXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "taken while busy")
  `IRTCL_ASSERT_IMP(a_cnt_step, !$stable(cnt_q), cnt_q == $past(cnt_q) + 1'b1 || cnt_q == '0, "cnt jump")
  `IRTCL_ASSERT_IMP(a_cnt_src, !$stable(cnt_q), $past(uw.op) == irtcl_pkg::OP_CAL_WRITE, "cnt moved")
  `IRTCL_ASSERT_IMP(a_hwm_grows, !$stable(hwm_q), hwm_q > $past(hwm_q), "fill mark moved down")
  `IRTCL_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(uw.op) == irtcl_pkg::OP_OUT, "stray result")

endmodule
